// ===== sv/sfdl_pkg.sv =====
// ----------------------------------------------------------------------------
// sfdl_pkg
// Types, constants and arithmetic helpers shared by the stereo delay line.
// ----------------------------------------------------------------------------
package sfdl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [16:0] UNITY     = 17'h10000;
  localparam logic [15:0] FB_MAX    = 16'd63570;  // 0.97 in Q0.16
  localparam logic [15:0] SEND_GAIN = 16'd45875;  // 0.7 in Q0.16

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_EN  = 3'd0,
    REG_WET_MIX   = 3'd1,
    REG_TAIL_MIX  = 3'd2,
    REG_FADER     = 3'd3,
    REG_LEN_LEFT  = 3'd4,
    REG_LEN_RIGHT = 3'd5,
    REG_FEEDBACK  = 3'd6
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SMOOTH,
    ST_READ0,
    ST_READ1,
    ST_INTERP,
    ST_WRITE,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic smooth;
    logic read0;
    logic read1;
    logic interp;
    logic write;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  // one-pole step: cur + (tgt - cur) / 2^sh, toward zero, at least one LSB
  function automatic logic signed [33:0] smooth_step(input logic signed [33:0] cur,
                                                     input logic signed [33:0] tgt,
                                                     input int sh);
    logic signed [33:0] d;
    logic [33:0]        mag;
    logic [33:0]        st;
    d   = tgt - cur;
    mag = d[33] ? 34'(-d) : 34'(d);
    st  = mag >> sh;
    if (st == 34'd0 && d != 34'sd0) st = 34'd1;
    return d[33] ? (cur - $signed(st)) : (cur + $signed(st));
  endfunction

  // round Q16 product to nearest, halves up
  function automatic logic signed [47:0] round16(input logic signed [47:0] v);
    return (v + 48'sd32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    if (v < -48'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

endpackage

// ===== sv/sfdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfdl_ctrl
// Sequencer: clearing pass after reset, then one item through the datapath.
// ----------------------------------------------------------------------------
module sfdl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sfdl_pkg::sts_t sts_i,
  output sfdl_pkg::cmd_t cmd_o
);
  import sfdl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_SMOOTH;
      ST_SMOOTH: state_d = ST_READ0;
      ST_READ0:  state_d = ST_READ1;
      ST_READ1:  state_d = ST_INTERP;
      ST_INTERP: state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_DONE;
      ST_DONE:   if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR:  cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SMOOTH: cmd_o.smooth = 1'b1;
      ST_READ0:  cmd_o.read0 = 1'b1;
      ST_READ1:  cmd_o.read1 = 1'b1;
      ST_INTERP: cmd_o.interp = 1'b1;
      ST_WRITE:  cmd_o.write = 1'b1;
      ST_DONE:   cmd_o.done = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/sfdl_datapath.sv =====
// ----------------------------------------------------------------------------
// sfdl_datapath
// Config registers, smoothers, delay memories, interpolation, mix and peak.
// ----------------------------------------------------------------------------
module sfdl_datapath #(
  parameter int LINE_DEPTH   = 65536,
  parameter int SMOOTH_SHIFT = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfdl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfdl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [23:0]              in_left_i,
  input  logic signed [23:0]              in_right_i,
  input  logic signed [23:0]              send_sample_i,
  input  logic                            block_start_i,
  input  sfdl_pkg::cmd_t                  cmd_i,
  output sfdl_pkg::sts_t                  sts_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [23:0]              out_left_o,
  output logic signed [23:0]              out_right_o,
  output logic [23:0]                     peak_level_o
);
  import sfdl_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  // configuration registers
  logic        en_q, mode_q;
  logic [16:0] wet_q, tail_q;
  logic [15:0] lenl_q, lenr_q, fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      wet_q  <= '0;
      tail_q <= '0;
      mode_q <= 1'b0;
      lenl_q <= 16'd1;
      lenr_q <= 16'd1;
      fb_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_DELAY_EN:  en_q   <= cfg_data_i[0];
        REG_WET_MIX:   wet_q  <= cfg_data_i;
        REG_TAIL_MIX:  tail_q <= cfg_data_i;
        REG_FADER:     mode_q <= cfg_data_i[0];
        REG_LEN_LEFT:  lenl_q <= cfg_data_i[15:0];
        REG_LEN_RIGHT: lenr_q <= cfg_data_i[15:0];
        REG_FEEDBACK:  fb_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // clamped targets
  logic [16:0] tgt_feed, tgt_mix_raw, tgt_mix;
  logic [15:0] tl, tr, fb_c;
  assign tgt_feed    = en_q ? UNITY : 17'd0;
  assign tgt_mix_raw = en_q ? wet_q : tail_q;
  assign tgt_mix     = (tgt_mix_raw > UNITY) ? UNITY : tgt_mix_raw;
  assign tl          = (lenl_q == 16'd0) ? 16'd1 : lenl_q;
  assign tr          = (lenr_q == 16'd0) ? 16'd1 : lenr_q;
  assign fb_c        = (fb_q > FB_MAX) ? FB_MAX : fb_q;

  // item registers
  logic signed [23:0] l_q, r_q, s_q;
  logic               start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q     <= in_left_i;
      r_q     <= in_right_i;
      s_q     <= send_sample_i;
      start_q <= block_start_i;
    end
  end

  // smoothers and write pointer
  logic [16:0]   fg_q, mix_q;
  logic [31:0]   lls_q, lrs_q;
  logic [AW-1:0] wi_q, clr_q;
  logic [23:0]   peak_q;
  logic          out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q  <= '0;
      mix_q <= '0;
      lls_q <= '0;
      lrs_q <= '0;
      wi_q  <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + AW'(1);
      if (cmd_i.smooth) begin
        fg_q  <= 17'(smooth_step($signed({17'd0, fg_q}), $signed({17'd0, tgt_feed}),
                                 SMOOTH_SHIFT));
        mix_q <= 17'(smooth_step($signed({17'd0, mix_q}), $signed({17'd0, tgt_mix}),
                                 SMOOTH_SHIFT));
        lls_q <= 32'(smooth_step($signed({2'd0, lls_q}), $signed({2'd0, tl, 16'd0}),
                                 SMOOTH_SHIFT));
        lrs_q <= 32'(smooth_step($signed({2'd0, lrs_q}), $signed({2'd0, tr, 16'd0}),
                                 SMOOTH_SHIFT));
      end
      if (cmd_i.write) wi_q <= wi_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(LINE_DEPTH - 1));

  // tap addresses
  logic [AW-1:0] r0l, r0r, r1l, r1r;
  assign r0l = wi_q - AW'(lls_q[31:16]);
  assign r0r = wi_q - AW'(lrs_q[31:16]);
  assign r1l = r0l - AW'(1);
  assign r1r = r0r - AW'(1);

  // memory port selection
  logic [AW-1:0]      addr_l, addr_r;
  logic               we;
  logic signed [23:0] wd_l, wd_r, wr_l, wr_r;

  always_comb begin
    addr_l = wi_q;
    addr_r = wi_q;
    we     = cmd_i.clr | cmd_i.write;
    wd_l   = cmd_i.clr ? 24'sd0 : wr_l;
    wd_r   = cmd_i.clr ? 24'sd0 : wr_r;
    if (cmd_i.clr) begin
      addr_l = clr_q;
      addr_r = clr_q;
    end else if (cmd_i.read0) begin
      addr_l = r0l;
      addr_r = r0r;
    end else if (cmd_i.read1) begin
      addr_l = r1l;
      addr_r = r1r;
    end
  end

  // delay memories
  logic signed [23:0] mem_l [LINE_DEPTH];
  logic signed [23:0] mem_r [LINE_DEPTH];
  logic signed [23:0] rdl_q, rdr_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_l[addr_l] <= wd_l;
    rdl_q <= mem_l[addr_l];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_r[addr_r] <= wd_r;
    rdr_q <= mem_r[addr_r];
  end

  // arithmetic pipeline
  logic signed [23:0] ssend_q, d0l_q, d0r_q, dl_q, dr_q, ol_q, or_q;
  logic [16:0]        gscale_q;
  logic signed [24:0] inl_q, inr_q;
  logic [16:0]        fracl, fracr, ufracl, ufracr, umix;

  assign fracl  = {1'b0, lls_q[15:0]};
  assign fracr  = {1'b0, lrs_q[15:0]};
  assign ufracl = UNITY - fracl;
  assign ufracr = UNITY - fracr;
  assign umix   = UNITY - mix_q;

  assign wr_l = sat24(round16(48'(dl_q) * 48'($signed({1'b0, fb_c}))) + 48'(inl_q));
  assign wr_r = sat24(round16(48'(dr_q) * 48'($signed({1'b0, fb_c}))) + 48'(inr_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.smooth)
      ssend_q <= 24'(round16(48'(s_q) * 48'($signed({1'b0, SEND_GAIN}))));
    if (cmd_i.read0)
      gscale_q <= mode_q ?
                  17'(round16(48'($signed({1'b0, fg_q})) * 48'($signed({1'b0, mix_q})))) :
                  fg_q;
    if (cmd_i.read1) begin
      d0l_q <= rdl_q;
      d0r_q <= rdr_q;
      inl_q <= 25'(round16(48'($signed({1'b0, gscale_q})) * 48'(l_q)) + 48'(ssend_q));
      inr_q <= 25'(round16(48'($signed({1'b0, gscale_q})) * 48'(r_q)) + 48'(ssend_q));
    end
    // interpolate between the tap cell and the next older one
    if (cmd_i.interp) begin
      dl_q <= 24'(round16(48'(d0l_q) * 48'($signed({1'b0, ufracl})) +
                          48'(rdl_q) * 48'($signed(fracl))));
      dr_q <= 24'(round16(48'(d0r_q) * 48'($signed({1'b0, ufracr})) +
                          48'(rdr_q) * 48'($signed(fracr))));
    end
    // output mix: crossfade or dry plus wet
    if (cmd_i.write) begin
      if (!mode_q) begin
        ol_q <= sat24(round16(48'(l_q) * 48'($signed({1'b0, umix})) +
                              48'(dl_q) * 48'($signed({1'b0, mix_q}))));
        or_q <= sat24(round16(48'(r_q) * 48'($signed({1'b0, umix})) +
                              48'(dr_q) * 48'($signed({1'b0, mix_q}))));
      end else begin
        ol_q <= sat24(48'(l_q) + 48'(dl_q));
        or_q <= sat24(48'(r_q) + 48'(dr_q));
      end
    end
  end

  // wet peak
  logic signed [24:0] wdl, wdr;
  logic [24:0]        wal, war, pbase, pm;
  assign wdl   = 25'(ol_q) - 25'(l_q);
  assign wdr   = 25'(or_q) - 25'(r_q);
  assign wal   = wdl[24] ? 25'(-wdl) : 25'(wdl);
  assign war   = wdr[24] ? 25'(-wdr) : 25'(wdr);
  assign pbase = start_q ? 25'd0 : {1'b0, peak_q};

  always_comb begin
    pm = pbase;
    if (wal > pm) pm = wal;
    if (war > pm) pm = war;
  end

  // output register
  logic               out_valid_q;
  logic signed [23:0] out_l_q, out_r_q;

  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else if (cmd_i.done && out_free) begin
      out_valid_q <= 1'b1;
      peak_q      <= pm[24] ? 24'hFFFFFF : pm[23:0];
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done && out_free) begin
      out_l_q <= ol_q;
      out_r_q <= or_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_left_o   = out_l_q;
  assign out_right_o  = out_r_q;
  assign peak_level_o = peak_q;

endmodule

// ===== sv/stereo_feedback_delay_line_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line_unit
// Stereo fractional feedback delay with smoothed gains and wet peak meter.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  cfg      in         cfg_we_i                  cfg_idx_i, cfg_data_i
//  in       in         in_valid_i / in_stall_o   in_left, in_right, send_sample, block_start
//  out      out        out_valid_o / out_stall_i out_left, out_right, peak_level
//
//  After an item is accepted the sequencer steps through SMOOTH, READ0, READ1,
//  INTERP, WRITE and DONE, where the output register loads; no new item is
//  taken until it is back in IDLE. The two taps of each channel are read one
//  after the other from a single-port memory, then the feedback write goes to the same port.
//  After reset a clearing pass zeroes every cell of both lines, with
//  in_stall_o high; configuration writes are taken during it.
//  A stalled output holds the sequencer in its last step until the result moves.
//  LINE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_line_unit #(
  parameter int LINE_DEPTH   = 65536,
  parameter int SMOOTH_SHIFT = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfdl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfdl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [23:0]              in_left_i,
  input  logic signed [23:0]              in_right_i,
  input  logic signed [23:0]              send_sample_i,
  input  logic                            block_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [23:0]              out_left_o,
  output logic signed [23:0]              out_right_o,
  output logic [23:0]                     peak_level_o
);
  import sfdl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfdl_datapath #(
    .LINE_DEPTH   (LINE_DEPTH),
    .SMOOTH_SHIFT (SMOOTH_SHIFT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_left_i     (in_left_i),
    .in_right_i    (in_right_i),
    .send_sample_i (send_sample_i),
    .block_start_i (block_start_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_left_o    (out_left_o),
    .out_right_o   (out_right_o),
    .peak_level_o  (peak_level_o)
  );

endmodule

// ===== dv/stereo_feedback_delay_line_unit_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line_unit_tb
// Self-checking bench for the stereo feedback delay. A behavioral echo model
// tracks both delay memories, smoothers and peak meter; each random-phase
// item is compared with it. A directed table runs first, then random phases
// under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stereo_feedback_delay_line_unit_tb;
  import sfdl_pkg::*;

  localparam int DEPTH       = 65536;
  localparam int SHIFT       = 10;
  localparam int ITEMS_PHASE = 305;
  localparam int DRAIN_WAIT  = 16;
  localparam int WDOG_LIMIT  = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [23:0]        peak;
  } echo_out_t;

  typedef struct {
    logic signed [23:0] l;
    logic signed [23:0] r;
    logic signed [23:0] s;
    logic               bs;
  } sample_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [23:0] in_left_i = '0, in_right_i = '0, send_sample_i = '0;
  logic block_start_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] out_left_o, out_right_o;
  logic [23:0] peak_level_o;

  stereo_feedback_delay_line_unit DUT (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // echo model state
  int     echo_line_l[DEPTH];
  int     echo_line_r[DEPTH];
  int     echo_wr;
  longint feed_s, mix_s, lenl_s, lenr_s, peak_s;
  longint m_en, m_wet, m_tail, m_fader, m_lenl, m_lenr, m_fb;

  echo_out_t echo_expect_q[$];
  int  errors = 0;
  int  snd_idle_pct = 0, rcv_stall_pct = 0;
  bit  hold_req = 0;
  bit  in_acc, out_acc;

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint glide(longint cur, longint tgt);
    longint d, st;
    d  = tgt - cur;
    st = (d >= 0) ? (d >>> SHIFT) : -((-d) >>> SHIFT);
    if (st == 0 && d != 0) st = (d > 0) ? 1 : -1;
    return cur + st;
  endfunction

  // interpolated read, len in Q16.16
  function automatic longint tap_read(bit right, longint len_q);
    int li, r0, r1;
    longint frac, a, b;
    li   = int'((len_q >> 16) % DEPTH);
    frac = len_q & 64'hFFFF;
    r0   = (echo_wr + DEPTH - li) % DEPTH;
    r1   = (r0 + DEPTH - 1) % DEPTH;
    a    = right ? echo_line_r[r0] : echo_line_l[r0];
    b    = right ? echo_line_r[r1] : echo_line_l[r1];
    return rnd16(a * (65536 - frac) + b * frac);
  endfunction

  function automatic void echo_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DELAY_EN:  m_en    = d[0];
      REG_WET_MIX:   m_wet   = d;
      REG_TAIL_MIX:  m_tail  = d;
      REG_FADER:     m_fader = d[0];
      REG_LEN_LEFT:  m_lenl  = d[15:0];
      REG_LEN_RIGHT: m_lenr  = d[15:0];
      REG_FEEDBACK:  m_fb    = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic echo_out_t echo_step(sample_row_t it);
    longint l, r, s, tf, tm, tl, tr, fb, ss, gs, il, ir, dl, dr, ol, orr, wl, wr;
    bit mixm;
    echo_out_t o;
    l = it.l; r = it.r; s = it.s;
    mixm = (m_fader == 0);
    tf = m_en ? 65536 : 0;
    tm = m_en ? m_wet : m_tail;
    if (tm > 65536) tm = 65536;
    tl = m_lenl ? m_lenl : 1;
    tr = m_lenr ? m_lenr : 1;
    fb = (m_fb > 63570) ? 63570 : m_fb;
    feed_s = glide(feed_s, tf);
    mix_s  = glide(mix_s, tm);
    lenl_s = glide(lenl_s, tl << 16);
    lenr_s = glide(lenr_s, tr << 16);
    ss = rnd16(s * 45875);
    gs = mixm ? feed_s : rnd16(feed_s * mix_s);
    il = rnd16(gs * l) + ss;
    ir = rnd16(gs * r) + ss;
    dl = tap_read(0, lenl_s);
    dr = tap_read(1, lenr_s);
    echo_line_l[echo_wr] = int'(clip24(il + rnd16(dl * fb)));
    echo_line_r[echo_wr] = int'(clip24(ir + rnd16(dr * fb)));
    echo_wr = (echo_wr + 1) % DEPTH;
    if (mixm) begin
      ol  = clip24(rnd16(l * (65536 - mix_s) + dl * mix_s));
      orr = clip24(rnd16(r * (65536 - mix_s) + dr * mix_s));
    end else begin
      ol  = clip24(l + dl);
      orr = clip24(r + dr);
    end
    if (it.bs) peak_s = 0;
    wl = (ol - l < 0) ? l - ol : ol - l;
    wr = (orr - r < 0) ? r - orr : orr - r;
    if (wl > peak_s) peak_s = wl;
    if (wr > peak_s) peak_s = wr;
    if (peak_s > 24'hFFFFFF) peak_s = 24'hFFFFFF;
    o.left  = 24'(ol);
    o.right = 24'(orr);
    o.peak  = 24'(peak_s);
    return o;
  endfunction

  // wait until the block has drained
  task automatic wait_drained();
    while (echo_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // writes all registers plus an unused index
  task automatic program_regs(logic en, logic [16:0] wet, logic [16:0] tail, logic fader,
                              logic [15:0] ll, logic [15:0] lr, logic [15:0] fb);
    logic [CFG_IDX_W-1:0]  idx [8];
    logic [CFG_DATA_W-1:0] val [8];
    idx = '{REG_DELAY_EN, REG_WET_MIX, REG_TAIL_MIX, REG_FADER,
            REG_LEN_LEFT, REG_LEN_RIGHT, REG_FEEDBACK, REG_UNUSED};
    val = '{17'(en), wet, tail, 17'(fader), 17'(ll), 17'(lr), 17'(fb), 17'h1FFFF};
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      echo_cfg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // offers one item and waits for acceptance
  task automatic send_sample(sample_row_t it, bit typed, echo_out_t want);
    echo_out_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_left_i     <= it.l;
    in_right_i    <= it.r;
    send_sample_i <= it.s;
    block_start_i <= it.bs;
    do @(posedge clk_i); while (in_stall_o);
    pred = echo_step(it);
    echo_expect_q.push_back(typed ? want : pred);
  endtask

  function automatic logic signed [23:0] pick24();
    case ($urandom_range(7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'sh0;
      3: return 24'($signed($urandom_range(4095)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    sample_row_t it;
    echo_out_t   none;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      it.l  = pick24();
      it.r  = pick24();
      it.s  = $urandom_range(1) ? 24'sh0 : pick24();
      it.bs = ($urandom_range(15) == 0);
      send_sample(it, 0, none);
    end
    in_valid_i <= 1'b0;
  endtask

  // output checker and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    int        hold_cnt;
    echo_out_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (echo_expect_q.size() == 0) begin
          $display("%0t: unexpected item L=%0d R=%0d P=%0d", $time,
                   out_left_o, out_right_o, peak_level_o);
          errors++;
        end else begin
          e = echo_expect_q.pop_front();
          if (e.left !== out_left_o) begin
            $display("%0t: out_left exp %0d got %0d", $time, e.left, out_left_o);
            errors++;
          end
          if (e.right !== out_right_o) begin
            $display("%0t: out_right exp %0d got %0d", $time, e.right, out_right_o);
            errors++;
          end
          if (e.peak !== peak_level_o) begin
            $display("%0t: peak_level exp %0d got %0d", $time, e.peak, peak_level_o);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk_i) begin
    int quiet;
    in_acc  = in_valid_i && !in_stall_o;
    out_acc = out_valid_o && !out_stall_i;
    if (in_acc || out_acc) quiet = 0;
    else quiet++;
    if (quiet >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d items outstanding", $time, echo_expect_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    sample_row_t dir_tbl [$];
    echo_out_t   want;
    feed_s = 0; mix_s = 0; lenl_s = 0; lenr_s = 0; peak_s = 0; echo_wr = 0;
    m_en = 0; m_wet = 0; m_tail = 0; m_fader = 0; m_lenl = 1; m_lenr = 1; m_fb = 0;

    // directed: reset settings give a dry pass-through with zero peak
    dir_tbl = '{
      '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1},
      '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0},
      '{24'sh0,      24'sh0,      24'sh0,      1'b0},
      '{24'sh000001, 24'shFFFFFF, 24'sh555555, 1'b1},
      '{24'shFFFFFF, 24'sh000001, 24'shAAAAAA, 1'b0},
      '{24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 1'b0},
      '{24'shAAAAAA, 24'sh555555, 24'sh800000, 1'b1},
      '{24'sh123456, 24'shEDCBA9, 24'sh000001, 1'b0},
      '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh0,      1'b0},
      '{24'sh800000, 24'sh800000, 24'sh0,      1'b1}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      want.left  = dir_tbl[i].l;
      want.right = dir_tbl[i].r;
      want.peak  = '0;
      send_sample(dir_tbl[i], 1, want);
    end
    in_valid_i <= 1'b0;

    // mix above unity, feedback too high, zero length, unused index
    program_regs(1, 17'h1FFFF, 17'd20000, 0, 16'd0, 16'd3, 16'hFFFF);
    snd_idle_pct = 0; rcv_stall_pct = 0;
    random_phase(ITEMS_PHASE);

    // send mode with a long tap that wraps
    program_regs(1, 17'd32768, 17'd1000, 1, 16'hFFFF, 16'd17, 16'd40000);
    snd_idle_pct = 68; rcv_stall_pct = 0;
    random_phase(ITEMS_PHASE);

    // tail at full mix, receiver holds off to back up the input
    program_regs(0, 17'd5, 17'h10000, 0, 16'd5, 16'd2, 16'd63570);
    snd_idle_pct = 0; rcv_stall_pct = 68;
    hold_req = 1;
    random_phase(ITEMS_PHASE);

    program_regs(1, 17'd0, 17'h0FFFF, 1, 16'd1, 16'hFFFF, 16'd0);
    snd_idle_pct = 8; rcv_stall_pct = 8;
    random_phase(ITEMS_PHASE);

    program_regs(1, 17'h10000, 17'd0, 0, 16'd100, 16'd1, 16'd63571);
    snd_idle_pct = 68; rcv_stall_pct = 68;
    random_phase(ITEMS_PHASE);

    program_regs(0, 17'h0AAAA, 17'h15555, 1, 16'h5555, 16'hAAAA, 16'h8000);
    snd_idle_pct = 0; rcv_stall_pct = 0;
    random_phase(ITEMS_PHASE);

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
